>>> rtl/int_to_radix_digits_top_assert.svh
// Assertion macros for the checker file of this block.
`ifndef INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ITRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Port check failed in the same cycle.");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ITRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Port check failed in the following cycle.");

`endif

>>> rtl/itrd_pkg.sv
`timescale 1ns / 1ps

package itrd_pkg;

    // Legal radix range.
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;

    // ASCII anchors for the digit set.
    localparam logic [6:0] ASCII_DIGIT_0 = 7'h30;
    localparam logic [6:0] ASCII_DIGIT_9 = 7'h39;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7a;

    // Highest digit value and the count of decimal digits.
    localparam logic [5:0] DIGIT_MAX     = 6'd35;
    localparam logic [5:0] DECIMAL_COUNT = 6'd10;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Classification of one transaction, carried through the queue.
    typedef struct packed {
        logic bad_base;
        logic negative;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

    // Map a digit value to its ASCII code, lower case above nine.
    function automatic logic [6:0] digit_ascii(input logic [5:0] d);
        logic [5:0] c;
        c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        if (c < DECIMAL_COUNT)
        begin
            return ASCII_DIGIT_0 + {1'b0, c};
        end
        else
        begin
            return ASCII_LOWER_A + {1'b0, c - DECIMAL_COUNT};
        end
    endfunction

endpackage

>>> rtl/itrd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and one registered read port.
module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/itrd_fifo.sv
`timescale 1ns / 1ps

// Short queue between the classifier and the conversion engine.
module itrd_fifo #(
    parameter int DATA_W = 72
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(itrd_pkg::QUEUE_DEPTH);

    logic [DATA_W-1:0] entry_reg [itrd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (PTR_W + 1)'(itrd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointers wrap on their own since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/itrd_front.sv
`timescale 1ns / 1ps

// Accepts transactions, checks the radix and takes the magnitude of the value.
module itrd_front #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   cmd,
    input  logic [63:0]            value,
    input  logic [5:0]             radix,
    input  logic                   queue_full,
    output logic                   queue_push,
    output itrd_pkg::flags_t       cls_flags,
    output logic [5:0]             cls_radix,
    output logic [VALUE_WIDTH-1:0] cls_mag
);

    logic [VALUE_WIDTH-1:0] raw;
    logic                   base_bad;
    logic                   is_neg;

    assign req_ready  = !queue_full;
    assign queue_push = req_valid && !queue_full;

    // Classification: radix range and sign.
    always_comb
    begin
        raw      = value[VALUE_WIDTH-1:0];
        base_bad = (radix < itrd_pkg::RADIX_MIN) || (radix > itrd_pkg::RADIX_MAX);
        is_neg   = cmd && raw[VALUE_WIDTH-1] && !base_bad;
        cls_flags.bad_base = base_bad;
        cls_flags.negative = is_neg;
        cls_radix = radix;
        // The most negative value negates to itself, which is its exact magnitude.
        cls_mag = is_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    end

endmodule

>>> rtl/itrd_back.sv
`timescale 1ns / 1ps

// Conversion engine: bit-serial division per digit, digits kept in RAM,
// then sent out most significant first through an output register.
module itrd_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   queue_empty,
    output logic                   queue_pop,
    input  itrd_pkg::flags_t       job_flags,
    input  logic [5:0]             job_radix,
    input  logic [VALUE_WIDTH-1:0] job_mag,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [6:0]             digit_char,
    output logic                   negative,
    output logic                   bad_base,
    output logic                   last
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_BAD
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [5:0]             rem_reg;
    logic [5:0]             rem_next;
    logic [5:0]             radix_reg;
    logic [5:0]             radix_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [IDX_W-1:0]       bit_cnt_reg;
    logic [IDX_W-1:0]       bit_cnt_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [6:0]             char_reg;
    logic [6:0]             char_next;
    logic                   neg_out_reg;
    logic                   neg_out_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic                   last_reg;
    logic                   last_next;

    logic [6:0]             rem_ext;
    logic                   q_bit;
    logic [5:0]             rem_step;
    logic [VALUE_WIDTH-1:0] quo_step;
    logic                   last_bit;
    logic                   out_free;
    logic                   ram_we;
    logic                   ram_re;
    logic [5:0]             ram_rdata;

    // One restoring division step: bring down the next dividend bit.
    always_comb
    begin
        rem_ext  = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        q_bit    = (rem_ext >= {1'b0, radix_reg});
        rem_step = q_bit ? 6'(rem_ext - {1'b0, radix_reg}) : rem_ext[5:0];
        quo_step = {quo_reg[VALUE_WIDTH-2:0], q_bit};
        last_bit = (bit_cnt_reg == IDX_W'(VALUE_WIDTH - 1));
    end

    assign out_free = !out_valid_reg || rsp_ready;

    itrd_ram #(
        .WIDTH (6),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (rem_step),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: next state, datapath and output register loads.
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        char_next      = char_reg;
        neg_out_next   = neg_out_reg;
        bad_next       = bad_reg;
        last_next      = last_reg;
        queue_pop      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop    = 1'b1;
                    quo_next     = job_mag;
                    rem_next     = '0;
                    radix_next   = job_radix;
                    neg_next     = job_flags.negative;
                    bit_cnt_next = '0;
                    idx_next     = '0;
                    state_next   = job_flags.bad_base ? ST_BAD : ST_DIV;
                end
            end

            ST_DIV:
            begin
                quo_next     = quo_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (last_bit)
                begin
                    // Digit done: store it, then go on or start the readout.
                    ram_we       = 1'b1;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (quo_step == '0)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itrd_pkg::digit_ascii(ram_rdata);
                    neg_out_next   = neg_reg;
                    bad_next       = 1'b0;
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = '0;
                    neg_out_next   = 1'b0;
                    bad_next       = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            radix_reg     <= '0;
            neg_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            neg_out_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            bit_cnt_reg   <= bit_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            neg_out_reg   <= neg_out_next;
            bad_reg       <= bad_next;
            last_reg      <= last_next;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign negative   = neg_out_reg;
    assign bad_base   = bad_reg;
    assign last       = last_reg;

endmodule

>>> rtl/int_to_radix_digits_top.sv
`timescale 1ns / 1ps

// Integer to ASCII digits in any base from 2 to 36.
// Request channel (req_valid/req_ready): cmd selects unsigned (0) or signed (1),
// value holds the number (low VALUE_WIDTH bits used), radix the base.
// Response channel (rsp_valid/rsp_ready): one transaction per digit, most
// significant first, as ASCII '0'-'9' then 'a'-'z'; last marks the final digit,
// negative is set on every digit of a negative signed value. A radix outside
// 2..36 gives one transaction with bad_base and last set and digit_char zero.
// Each digit is worked out in the bit-serial divider and stored in the digit
// RAM, then read back from it for output; the engine finishes one request
// before it takes the next from the queue, and a bad radix needs no division.
// A two-entry queue sits ahead of the engine, so two more requests are taken
// while one converts. When rsp_ready is low the output register holds its
// transaction and the engine waits; the queue keeps accepting until full.
// Reset clears the queue, the engine and the output register; no clearing
// pass is needed and requests are taken in the first cycle after reset.
module int_to_radix_digits_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        cmd,
    input  logic [63:0] value,
    input  logic [5:0]  radix,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [6:0]  digit_char,
    output logic        negative,
    output logic        bad_base,
    output logic        last
);

    localparam int ENTRY_W = itrd_pkg::FLAGS_W + 6 + VALUE_WIDTH;

    logic                   queue_full;
    logic                   queue_empty;
    logic                   queue_push;
    logic                   queue_pop;
    itrd_pkg::flags_t       cls_flags;
    logic [5:0]             cls_radix;
    logic [VALUE_WIDTH-1:0] cls_mag;
    logic [ENTRY_W-1:0]     push_data;
    logic [ENTRY_W-1:0]     pop_data;
    itrd_pkg::flags_t       job_flags;
    logic [5:0]             job_radix;
    logic [VALUE_WIDTH-1:0] job_mag;

    // Front end: handshake and classification.
    itrd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .cmd        (cmd),
        .value      (value),
        .radix      (radix),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .cls_flags  (cls_flags),
        .cls_radix  (cls_radix),
        .cls_mag    (cls_mag)
    );

    assign push_data = {cls_flags, cls_radix, cls_mag};

    // Queue between front and back.
    itrd_fifo #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    assign {job_flags, job_radix, job_mag} = pop_data;

    // Back end: conversion and response register.
    itrd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_pop   (queue_pop),
        .job_flags   (job_flags),
        .job_radix   (job_radix),
        .job_mag     (job_mag),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .digit_char  (digit_char),
        .negative    (negative),
        .bad_base    (bad_base),
        .last        (last)
    );

endmodule

>>> rtl/itrd_checker.sv
`timescale 1ns / 1ps
`include "int_to_radix_digits_top_assert.svh"

// Port-level checks on the response channel.
module itrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        cmd,
    input logic [63:0] value,
    input logic [5:0]  radix,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [6:0]  digit_char,
    input logic        negative,
    input logic        bad_base,
    input logic        last
);

    logic legal_digit;

    // A digit is a decimal digit or a lower-case letter.
    assign legal_digit =
        ((digit_char >= itrd_pkg::ASCII_DIGIT_0) && (digit_char <= itrd_pkg::ASCII_DIGIT_9)) ||
        ((digit_char >= itrd_pkg::ASCII_LOWER_A) && (digit_char <= itrd_pkg::ASCII_LOWER_Z));

    // A stalled response keeps its payload.
    `ITRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(digit_char) && $stable(last) && $stable(negative) && $stable(bad_base))

    // A bad radix result is the empty string: one final transaction, no sign.
    `ITRD_ASSERT_SAME(a_bad_base_empty, rsp_valid && bad_base, (digit_char == '0) && last && !negative)

    // Every other result carries a character from the digit set.
    `ITRD_ASSERT_SAME(a_digit_legal, rsp_valid && !bad_base, legal_digit)

    // A bad radix result never follows a digit of an unfinished conversion.
    `ITRD_ASSERT_NEXT(a_no_bad_midstring, rsp_valid && rsp_ready && !last, !(rsp_valid && bad_base))

endmodule

bind int_to_radix_digits_top itrd_checker u_itrd_checker (.*);

>>> tb/int_to_radix_digits_top_tb.sv
`timescale 1ns / 1ps

module int_to_radix_digits_top_tb;

    localparam int VALUE_WIDTH = 64;
    localparam int RANDOM_REQUESTS = 210;
    localparam int CYCLE_LIMIT = 6000000;

    // One digit transaction as seen on the response channel.
    typedef struct packed {
        logic [6:0] digit_char;
        logic       negative;
        logic       bad_base;
        logic       last;
    } digit_rec_t;

    // Expected digit stream, fed by accepted requests and drained by responses.
    class digit_scoreboard;
        digit_rec_t expected_digits[$];

        function int pending();
            return expected_digits.size();
        endfunction

        // Convert one accepted request into its expected digit transactions.
        function void note_request(input bit is_signed, input logic [63:0] raw_value,
                                   input logic [5:0] base);
            logic [63:0] width_mask;
            logic [63:0] magnitude;
            logic [5:0]  digit_vals[64];
            int          count;
            bit          is_negative;
            digit_rec_t  rec;
            width_mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
            if (base < itrd_pkg::RADIX_MIN || base > itrd_pkg::RADIX_MAX)
            begin
                rec.digit_char = '0;
                rec.negative = 1'b0;
                rec.bad_base = 1'b1;
                rec.last = 1'b1;
                expected_digits.push_back(rec);
                return;
            end
            is_negative = is_signed && raw_value[VALUE_WIDTH-1];
            if (is_negative)
            begin
                magnitude = (~raw_value + 64'd1) & width_mask;
            end
            else
            begin
                magnitude = raw_value & width_mask;
            end
            // Collect digits least significant first.
            count = 0;
            do
            begin
                digit_vals[count] = 6'(magnitude % {58'd0, base});
                count++;
                magnitude = magnitude / {58'd0, base};
            end
            while (magnitude != 64'd0 && count < 64);
            // Emit them most significant first.
            for (int k = count - 1; k >= 0; k--)
            begin
                if (digit_vals[k] < itrd_pkg::DECIMAL_COUNT)
                begin
                    rec.digit_char = itrd_pkg::ASCII_DIGIT_0 + {1'b0, digit_vals[k]};
                end
                else
                begin
                    rec.digit_char = itrd_pkg::ASCII_LOWER_A + {1'b0, digit_vals[k]}
                                     - {1'b0, itrd_pkg::DECIMAL_COUNT};
                end
                rec.negative = is_negative;
                rec.bad_base = 1'b0;
                rec.last = (k == 0);
                expected_digits.push_back(rec);
            end
        endfunction

        // Compare one response transaction with the oldest expectation.
        function string check_digit(input digit_rec_t got);
            digit_rec_t want;
            string      msg;
            msg = "";
            if (expected_digits.size() == 0)
            begin
                return $sformatf("unexpected digit char=%0h neg=%0b bad=%0b last=%0b",
                                 got.digit_char, got.negative, got.bad_base, got.last);
            end
            want = expected_digits.pop_front();
            if (got.digit_char !== want.digit_char)
            begin
                msg = {msg, $sformatf(" digit_char got %0h want %0h",
                                      got.digit_char, want.digit_char)};
            end
            if (got.negative !== want.negative)
            begin
                msg = {msg, $sformatf(" negative got %0b want %0b",
                                      got.negative, want.negative)};
            end
            if (got.bad_base !== want.bad_base)
            begin
                msg = {msg, $sformatf(" bad_base got %0b want %0b",
                                      got.bad_base, want.bad_base)};
            end
            if (got.last !== want.last)
            begin
                msg = {msg, $sformatf(" last got %0b want %0b", got.last, want.last)};
            end
            return msg;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        cmd = 1'b0;
    logic [63:0] value = '0;
    logic [5:0]  radix = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [6:0]  digit_char;
    logic        negative;
    logic        bad_base;
    logic        last;

    digit_scoreboard sb;
    int              mismatches = 0;
    int              cycle_count = 0;
    bit              calm = 1'b0;

    int_to_radix_digits_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .cmd(cmd),
        .value(value),
        .radix(radix),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .digit_char(digit_char),
        .negative(negative),
        .bad_base(bad_base),
        .last(last)
    );

    always #6 clk = ~clk;

    // Report one mismatch on a line of its own and count it.
    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d:%s", cycle_count, msg);
        mismatches++;
    endtask

    // Present one request, optionally after a short idle gap, and wait for it
    // to be taken. Valid is left high; the next call or the end lowers it.
    task automatic send_request(input bit c, input logic [63:0] v, input logic [5:0] r);
        if (!calm && $urandom_range(99) < 10)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd <= c;
        value <= v;
        radix <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        sb.note_request(c, v, r);
    endtask

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL int_to_radix_digits_top");
            $finish;
        end
    end

    // Response side: check each accepted transaction and stall at random.
    always @(posedge clk)
    begin : rsp_sink
        string msg;
        digit_rec_t got;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got.digit_char = digit_char;
            got.negative = negative;
            got.bad_base = bad_base;
            got.last = last;
            msg = sb.check_digit(got);
            if (msg.len() != 0)
            begin
                report_mismatch(msg);
            end
        end
        rsp_ready <= rst_n && (calm || $urandom_range(99) >= 10);
    end

    initial
    begin
        int          nbits;
        logic [63:0] v;
        logic [5:0]  r;
        bit          c;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero, extremes of value and radix, sign cases, bad radix.
        send_request(1'b0, 64'd0, 6'd10);
        send_request(1'b1, 64'd0, 6'd2);
        send_request(1'b0, {64{1'b1}}, 6'd2);
        send_request(1'b0, {64{1'b1}}, 6'd36);
        send_request(1'b1, 64'h8000_0000_0000_0000, 6'd2);
        send_request(1'b1, 64'h8000_0000_0000_0000, 6'd10);
        send_request(1'b0, 64'h8000_0000_0000_0000, 6'd10);
        send_request(1'b1, {64{1'b1}}, 6'd16);
        send_request(1'b1, 64'h7fff_ffff_ffff_ffff, 6'd36);
        send_request(1'b0, 64'd35, 6'd35);
        send_request(1'b0, 64'd36, 6'd36);
        send_request(1'b0, 64'd1234567890, 6'd10);
        send_request(1'b1, 64'h0000_0000_dead_beef, 6'd16);
        send_request(1'b1, 64'hffff_ffff_ffff_fff9, 6'd3);
        send_request(1'b0, 64'd1, 6'd2);
        send_request(1'b1, 64'hffff_ffff_ffff_ffff, 6'd0);
        send_request(1'b0, 64'd12345, 6'd1);
        send_request(1'b0, 64'd12345, 6'd37);
        send_request(1'b1, 64'h8000_0000_0000_0000, 6'd63);
        send_request(1'b0, 64'h0123_4567_89ab_cdef, 6'd8);

        // Random: mostly legal radices; value sizes spread evenly over bit lengths.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            calm = (i >= 80 && i < 150);
            c = 1'($urandom_range(1));
            nbits = int'($urandom_range(64));
            v = {$urandom, $urandom};
            if (nbits < 64)
            begin
                v = v & ((64'd1 << nbits) - 64'd1);
            end
            if (c && $urandom_range(1))
            begin
                v = ~v;
            end
            if ($urandom_range(99) < 10)
            begin
                r = 6'($urandom_range(63));
            end
            else
            begin
                r = 6'($urandom_range(36, 2));
            end
            send_request(c, v, r);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // Drain the remaining digits, then allow for any stray output.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS int_to_radix_digits_top");
        end
        else
        begin
            $display("FAIL int_to_radix_digits_top");
        end
        $finish;
    end

endmodule
